@@ rtl/core/led_pkg.sv @@
package led_pkg;

  // widths of the stream fields, fixed by the item layout
  localparam int SYM_W       = 8;
  localparam int OUT_W       = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 1;

  // sequencer state codes
  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_ROW  = 3'd2;
  localparam logic [2:0] ST_CELL = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

endpackage

@@ rtl/core/levenshtein_edit_distance_core.sv @@
// levenshtein edit distance core
//
// input stream (s_axis): one item carries at most one source symbol and one
// target symbol, each with its own flag in tuser. symbols are appended to two
// buffers of MAX_LEN entries; symbols beyond that are dropped and flagged.
// an item with tlast set closes the pair and starts the distance run.
// output stream (m_axis): one item per pair, distance and source length in
// tdata, the overflow flag in tuser.
//
// an item without tlast is accepted whenever the core is loading. after
// tlast the core fills the cost row, then one shared cell walks the table
// row by row (a row set-up step, then one cell per cycle), then the result
// is handed to the output register; when either string is empty the core
// goes from the fill straight to the output step. the cost row memory is
// read and written once per cycle.
// s_axis_tready is low during the run. a result waiting in the output
// register does not stop loading of the next pair; only a second finished
// result waits until the receiver takes the first.
// reset clears counts, overflow flag, sequencer and output valid; buffers and
// the cost row need no clearing since they are written before they are read.
module levenshtein_edit_distance_core
  import led_pkg::*;
#(
  parameter int MAX_LEN  = 64,
  parameter int SYM_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // src_sym[7:0], tgt_sym[15:8]
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // src_valid[0], tgt_valid[1]
  input  logic                   s_axis_tlast,   // last
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // distance[6:0], src_length[13:7], zeros
  output logic [OUT_TUSER_W-1:0] m_axis_tuser    // overflow[0]
);

  // count width holds 0..MAX_LEN, address width indexes the symbol buffers
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SB = (SYM_BITS < SYM_W) ? SYM_BITS : SYM_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);
  localparam logic [CW-1:0] ONE     = CW'(1);

  // symbol buffers and the single cost row
  logic [SB-1:0] src_mem  [MAX_LEN];
  logic [SB-1:0] tgt_mem  [MAX_LEN];
  logic [CW-1:0] cost_mem [MAX_LEN+1];

  logic [2:0]    state;
  logic [CW-1:0] src_count;
  logic [CW-1:0] tgt_count;
  logic          overflow_seen;

  // run registers
  logic [CW-1:0] n_len;
  logic [CW-1:0] m_len;
  logic          ovf_hold;
  logic [CW-1:0] row_i;
  logic [CW-1:0] col_j;
  logic [CW-1:0] left;
  logic [CW-1:0] diag;
  logic [CW-1:0] edit_dist;

  // registered read data
  logic [SB-1:0] src_rd;
  logic [SB-1:0] tgt_rd;
  logic [CW-1:0] cost_rd;

  // output register
  logic          out_valid;
  logic [CW-1:0] out_dist;
  logic [CW-1:0] out_len;
  logic          out_ovf;

  logic [SB-1:0] src_sym;
  logic [SB-1:0] tgt_sym;
  logic          src_valid;
  logic          tgt_valid;
  logic          in_accept;
  logic          src_full;
  logic          tgt_full;
  logic          src_take;
  logic          tgt_take;
  logic [CW-1:0] src_count_next;
  logic [CW-1:0] tgt_count_next;
  logic          overflow_next;

  logic          cost_we;
  logic [CW-1:0] cost_waddr;
  logic [CW-1:0] cost_wdata;
  logic [CW-1:0] rd_j;
  logic [CW-1:0] tgt_rd_j;
  logic [CW-1:0] src_rd_i;
  logic [CW-1:0] cell_cost;
  logic          out_load;

  logic [CW+OUT_W-1:0] dist_ext;
  logic [CW+OUT_W-1:0] len_ext;

  assign src_sym   = s_axis_tdata[SB-1:0];
  assign tgt_sym   = s_axis_tdata[SYM_W +: SB];
  assign src_valid = s_axis_tuser[0];
  assign tgt_valid = s_axis_tuser[1];

  assign s_axis_tready = (state == ST_LOAD);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // loader: append while room is left, flag anything past the end
  assign src_full = (src_count == MAX_CNT);
  assign tgt_full = (tgt_count == MAX_CNT);
  assign src_take = in_accept && src_valid && !src_full;
  assign tgt_take = in_accept && tgt_valid && !tgt_full;

  assign src_count_next = src_take ? src_count + ONE : src_count;
  assign tgt_count_next = tgt_take ? tgt_count + ONE : tgt_count;
  assign overflow_next  = overflow_seen || (in_accept && src_valid && src_full)
                          || (in_accept && tgt_valid && tgt_full);

  always_ff @(posedge clk) begin
    if (src_take) begin
      src_mem[src_count[AW-1:0]] <= src_sym;
    end
    if (tgt_take) begin
      tgt_mem[tgt_count[AW-1:0]] <= tgt_sym;
    end
  end

  // read addresses: the cell after the current one, or the first cell of a row
  always_comb begin
    if (state == ST_CELL && col_j != m_len) begin
      rd_j = col_j + ONE;
    end else begin
      rd_j = ONE;
    end
    tgt_rd_j = rd_j - ONE;
    src_rd_i = row_i - ONE;
  end

  always_ff @(posedge clk) begin
    cost_rd <= cost_mem[rd_j];
    tgt_rd  <= tgt_mem[tgt_rd_j[AW-1:0]];
    if (state == ST_ROW) begin
      src_rd <= src_mem[src_rd_i[AW-1:0]];
    end
  end

  // the shared table cell
  led_cell #(
    .W (CW)
  ) u_cell (
    .above (cost_rd),
    .left  (left),
    .diag  (diag),
    .match (src_rd == tgt_rd),
    .cost  (cell_cost)
  );

  // cost row write port: boundary fill, row head, or cell result
  always_comb begin
    cost_we    = 1'b0;
    cost_waddr = col_j;
    cost_wdata = cell_cost;
    case (state)
      ST_INIT: begin
        cost_we    = 1'b1;
        cost_waddr = col_j;
        cost_wdata = col_j;
      end
      ST_ROW: begin
        cost_we    = 1'b1;
        cost_waddr = '0;
        cost_wdata = row_i;
      end
      ST_CELL: begin
        cost_we    = 1'b1;
        cost_waddr = col_j;
        cost_wdata = cell_cost;
      end
      default: begin
        cost_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[cost_waddr] <= cost_wdata;
    end
  end

  assign out_load = (state == ST_OUT) && (!out_valid || m_axis_tready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      src_count     <= '0;
      tgt_count     <= '0;
      overflow_seen <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_accept) begin
            if (s_axis_tlast) begin
              n_len         <= src_count_next;
              m_len         <= tgt_count_next;
              ovf_hold      <= overflow_next;
              src_count     <= '0;
              tgt_count     <= '0;
              overflow_seen <= 1'b0;
              col_j         <= '0;
              state         <= ST_INIT;
            end else begin
              src_count     <= src_count_next;
              tgt_count     <= tgt_count_next;
              overflow_seen <= overflow_next;
            end
          end
        end
        ST_INIT: begin
          if (col_j == m_len) begin
            // an empty string on either side leaves the other length
            if (n_len == '0 || m_len == '0) begin
              edit_dist <= (n_len == '0) ? m_len : n_len;
              state     <= ST_OUT;
            end else begin
              row_i <= ONE;
              state <= ST_ROW;
            end
          end else begin
            col_j <= col_j + ONE;
          end
        end
        ST_ROW: begin
          diag  <= row_i - ONE;
          left  <= row_i;
          col_j <= ONE;
          state <= ST_CELL;
        end
        ST_CELL: begin
          left <= cell_cost;
          diag <= cost_rd;
          if (col_j == m_len) begin
            if (row_i == n_len) begin
              edit_dist <= cell_cost;
              state     <= ST_OUT;
            end else begin
              row_i <= row_i + ONE;
              state <= ST_ROW;
            end
          end else begin
            col_j <= col_j + ONE;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_dist <= edit_dist;
      out_len  <= n_len;
      out_ovf  <= ovf_hold;
    end
  end

  // fields are the low seven bits of the counts
  assign dist_ext = {{OUT_W{1'b0}}, out_dist};
  assign len_ext  = {{OUT_W{1'b0}}, out_len};

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W - 2*OUT_W){1'b0}},
                          len_ext[OUT_W-1:0], dist_ext[OUT_W-1:0]};
  assign m_axis_tuser  = out_ovf;

endmodule

@@ rtl/core/led_cell.sv @@
module led_cell #(
  parameter int W = 7
) (
  input  logic [W-1:0] above,
  input  logic [W-1:0] left,
  input  logic [W-1:0] diag,
  input  logic         match,
  output logic [W-1:0] cost
);

  logic [W:0] del_cost;
  logic [W:0] ins_cost;
  logic [W:0] sub_cost;
  logic [W:0] min_ab;
  logic [W:0] min_all;

  // delete, insert and substitute, one extra bit so the +1 never wraps
  assign del_cost = {1'b0, above} + {{W{1'b0}}, 1'b1};
  assign ins_cost = {1'b0, left} + {{W{1'b0}}, 1'b1};
  assign sub_cost = {1'b0, diag} + {{W{1'b0}}, ~match};

  assign min_ab  = (del_cost < ins_cost) ? del_cost : ins_cost;
  assign min_all = (min_ab < sub_cost) ? min_ab : sub_cost;

  // a cell never exceeds the longest string, so the top bit is free
  assign cost = min_all[W-1:0];

endmodule

@@ bench/testbench.sv @@
module testbench;
  import led_pkg::*;

  localparam int STR_MAX      = 64;
  localparam int LIMIT_CYCLES = 500000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 200;

  typedef logic [SYM_W-1:0] sym_q_t[$];

  typedef struct {
    logic [OUT_W-1:0] distance;
    logic [OUT_W-1:0] src_length;
    logic             overflow;
  } score_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // src_sym[7:0], tgt_sym[15:8]
  logic [IN_TUSER_W-1:0]  s_axis_tuser;   // src_valid[0], tgt_valid[1]
  logic                   s_axis_tlast;   // last
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // distance[6:0], src_length[13:7], zeros
  logic [OUT_TUSER_W-1:0] m_axis_tuser;   // overflow[0]

  // predictor state: the strings as the block keeps them
  sym_q_t src_kept;
  sym_q_t tgt_kept;
  logic   trunc_seen;
  score_t scores_due[$];

  int  items_sent;
  int  error_count;
  int  cycle_count;
  int  hold_requests;
  int  hold_served;
  bit  idle_on;

  levenshtein_edit_distance_core #(
    .MAX_LEN  (STR_MAX),
    .SYM_BITS (SYM_W)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // unit-cost levenshtein over one rolling row
  function automatic score_t score_pair(input sym_q_t src, input sym_q_t tgt,
                                        input logic ovf);
    int     row [0:STR_MAX];
    int     diag;
    int     above;
    int     best;
    score_t s;
    for (int j = 0; j <= tgt.size(); j++) row[j] = j;
    for (int i = 1; i <= src.size(); i++) begin
      diag = row[0];
      row[0] = i;
      for (int j = 1; j <= tgt.size(); j++) begin
        above = row[j];
        best = diag + ((src[i-1] == tgt[j-1]) ? 0 : 1);
        if (above + 1 < best) best = above + 1;
        if (row[j-1] + 1 < best) best = row[j-1] + 1;
        row[j] = best;
        diag = above;
      end
    end
    s.distance   = OUT_W'(row[tgt.size()]);
    s.src_length = OUT_W'(src.size());
    s.overflow   = ovf;
    return s;
  endfunction

  // apply one accepted item to the predictor
  function automatic void absorb_item(input logic [SYM_W-1:0] ss, input logic sv,
                                      input logic [SYM_W-1:0] ts, input logic tv,
                                      input logic lst);
    if (sv) begin
      if (src_kept.size() < STR_MAX) src_kept = {src_kept, ss};
      else trunc_seen = 1'b1;
    end
    if (tv) begin
      if (tgt_kept.size() < STR_MAX) tgt_kept = {tgt_kept, ts};
      else trunc_seen = 1'b1;
    end
    if (lst) begin
      scores_due = {scores_due, score_pair(src_kept, tgt_kept, trunc_seen)};
      src_kept.delete();
      tgt_kept.delete();
      trunc_seen = 1'b0;
    end
  endfunction

  // called at a falling edge, returns at the falling edge after the handshake
  task automatic send_item(input logic [SYM_W-1:0] ss, input logic sv,
                           input logic [SYM_W-1:0] ts, input logic tv,
                           input logic lst);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  = {ts, ss};
    s_axis_tuser  = {tv, sv};
    s_axis_tlast  = lst;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    absorb_item(ss, sv, ts, tv, lst);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_scores();
    s_axis_tvalid = 1'b0;
    while (scores_due.size() != 0) @(negedge clk);
  endtask

  task automatic send_string_pair(input string a, input string b);
    int n;
    n = (a.len() > b.len()) ? a.len() : b.len();
    if (n == 0) n = 1;
    for (int k = 0; k < n; k++)
      send_item(k < a.len() ? SYM_W'(a[k]) : SYM_W'($urandom), k < a.len(),
                k < b.len() ? SYM_W'(b[k]) : SYM_W'($urandom), k < b.len(),
                k == n - 1);
  endtask

  // small alphabet around a random base so that matches are common
  task automatic send_sized_pair(input int n_src, input int n_tgt);
    logic [SYM_W-1:0] base;
    int               n;
    base = $urandom_range(0, 255);
    n = (n_src > n_tgt) ? n_src : n_tgt;
    for (int k = 0; k < n; k++)
      send_item(base + SYM_W'($urandom_range(0, 2)), k < n_src,
                base + SYM_W'($urandom_range(0, 2)), k < n_tgt, k == n - 1);
  endtask

  task automatic send_random_pair(input int n_items, input int valid_pct);
    logic [SYM_W-1:0] base;
    logic [SYM_W-1:0] ss;
    logic [SYM_W-1:0] ts;
    bit               narrow;
    base   = $urandom_range(0, 255);
    narrow = $urandom_range(0, 1);
    for (int k = 0; k < n_items; k++) begin
      ss = narrow ? base + SYM_W'($urandom_range(0, 2)) : SYM_W'($urandom_range(0, 255));
      ts = narrow ? base + SYM_W'($urandom_range(0, 2)) : SYM_W'($urandom_range(0, 255));
      send_item(ss, $urandom_range(0, 99) < valid_pct,
                ts, $urandom_range(0, 99) < valid_pct, k == n_items - 1);
    end
  endtask

  task automatic test_directed();
    send_string_pair("", "");
    send_string_pair("abc", "");
    send_string_pair("", "xy");
    send_string_pair("kitten", "sitting");
    send_string_pair("flaw", "lawn");
    send_string_pair("same", "same");
    // extreme symbols, an empty item and a closing item with no symbols
    send_item(8'h00, 1'b1, 8'hFF, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 8'hA5, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 8'h00, 1'b0, 1'b1);
    wait_for_scores();
  endtask

  // full buffers, truncation on each side, then a full source with an empty target
  task automatic test_long_strings();
    send_sized_pair(STR_MAX, STR_MAX);
    send_sized_pair(STR_MAX + 2, 40);
    send_sized_pair(10, STR_MAX + 1);
    send_sized_pair(STR_MAX, 0);
    wait_for_scores();
  endtask

  task automatic test_random_pairs(input int n_items, input bit with_idle);
    int stop;
    int r;
    idle_on = with_idle;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 5) send_random_pair($urandom_range(60, 80), 95);
      else if (r < 15) send_random_pair($urandom_range(1, 12), 20);
      else send_random_pair($urandom_range(1, 10), 75);
    end
    idle_on = 1'b1;
    wait_for_scores();
  endtask

  // receiver holds off while short pairs keep coming, so the core backs up
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_requests++;
    repeat (12) send_random_pair($urandom_range(1, 4), 75);
    idle_on = 1'b1;
    wait_for_scores();
  endtask

  task automatic test_drain_pause();
    repeat (5) send_random_pair($urandom_range(1, 6), 75);
    wait_for_scores();
    repeat (5) send_random_pair($urandom_range(1, 6), 75);
    wait_for_scores();
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    trunc_seen    = 1'b0;
    items_sent    = 0;
    hold_requests = 0;
    idle_on       = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_long_strings();
    test_random_pairs(130, 1'b1);
    test_random_pairs(40, 1'b0);
    test_backpressure();
    test_drain_pause();

    wait_for_scores();
    repeat (SETTLE) @(negedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver: random stalls plus a long hold when one is requested
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left    = 0;
    hold_left     = 0;
    hold_served   = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        stall_left    = idle_gap();
      end
    end
  end

  initial error_count = 0;

  always @(posedge clk) begin : check_scores
    score_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (scores_due.size() == 0) begin
        $error("result with no pair pending: tdata %h tuser %h", m_axis_tdata, m_axis_tuser);
        error_count++;
      end else begin
        want = scores_due.pop_front();
        if (m_axis_tdata[OUT_W-1:0] !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, m_axis_tdata[OUT_W-1:0]);
          error_count++;
        end
        if (m_axis_tdata[2*OUT_W-1:OUT_W] !== want.src_length) begin
          $error("src_length: expected %0d, got %0d", want.src_length,
                 m_axis_tdata[2*OUT_W-1:OUT_W]);
          error_count++;
        end
        if (m_axis_tdata[OUT_TDATA_W-1:2*OUT_W] !== '0) begin
          $error("tdata padding: expected 0, got %0h", m_axis_tdata[OUT_TDATA_W-1:2*OUT_W]);
          error_count++;
        end
        if (m_axis_tuser[0] !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, m_axis_tuser[0]);
          error_count++;
        end
      end
    end
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
